// ===== hdl/u8d_pkg.sv =====
// shared types and constants for the utf-8 code point decoder
`default_nettype none

package u8d_pkg;

   localparam int ByteWidth  = 8;
   localparam int CpWidth    = 21;
   localparam int MaxResults = 4;
   localparam int PendDepth  = 3;

   localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;
   localparam logic [CpWidth-1:0] MaxScalar     = 21'h10FFFF;
   localparam logic [CpWidth-1:0] SurrLow       = 21'h00D800;
   localparam logic [CpWidth-1:0] SurrHigh      = 21'h00DFFF;

   // everything one byte produces: its results and the new pending state
   typedef struct packed {
      logic [MaxResults-1:0][CpWidth-1:0]  cp;
      logic [2:0]                          cnt;
      logic [PendDepth-1:0][ByteWidth-1:0] pend_bytes;
      logic [1:0]                          pend_cnt;
   } decode_type;

endpackage

`default_nettype wire

// ===== hdl/u8d_decode.sv =====
// combinational decode of the pending bytes plus one new byte
`default_nettype none

module u8d_decode (
   input  wire logic [u8d_pkg::PendDepth-1:0][u8d_pkg::ByteWidth-1:0] pend_bytes,
   input  wire logic [1:0]                                            pend_cnt,
   input  wire logic [u8d_pkg::ByteWidth-1:0]                         text_byte,
   input  wire logic                                                  string_end,
   output u8d_pkg::decode_type                                        dec
);

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0)               len = 3'd1;
      else if (b[7:5] == 3'b110)      len = 3'd2;
      else if (b[7:4] == 4'b1110)     len = 3'd3;
      else if (b[7:3] == 5'b11110)    len = 3'd4;
      else                            len = 3'd0;
      return len;
   endfunction

   logic [7:0]                 bv  [4];
   logic [7:0]                 tmp [4];
   logic [2:0]                 nv;
   logic [2:0]                 need;
   logic [2:0]                 drop;
   logic [2:0]                 kc;
   logic [2:0]                 jd;
   logic                       stop;
   logic                       broken;
   logic [u8d_pkg::CpWidth-1:0] cp;
   logic [u8d_pkg::MaxResults-1:0][u8d_pkg::CpWidth-1:0] cps;

   always_comb begin
      // line up the pending bytes with the new one behind them
      for (int k = 0; k < u8d_pkg::PendDepth; k++) begin
         if (3'(k) < {1'b0, pend_cnt}) begin
            bv[k] = pend_bytes[k];
         end else if (3'(k) == {1'b0, pend_cnt}) begin
            bv[k] = text_byte;
         end else begin
            bv[k] = 8'h00;
         end
      end
      bv[3]  = (pend_cnt == 2'd3) ? text_byte : 8'h00;
      tmp    = bv;
      nv     = {1'b0, pend_cnt} + 3'd1;
      stop   = 1'b0;
      kc     = 3'd0;
      cps    = '0;
      need   = 3'd0;
      drop   = 3'd0;
      broken = 1'b0;
      cp     = '0;
      jd     = 3'd0;
      // every pass consumes bytes or stops, so four passes always finish
      for (int s = 0; s < 4; s++) begin
         if (!stop && nv != 3'd0) begin
            need   = seq_len(bv[0]);
            broken = 1'b0;
            cp     = '0;
            for (int i = 1; i < 4; i++) begin
               if (3'(i) < need && 3'(i) < nv && bv[i][7:6] != 2'b10) begin
                  broken = 1'b1;
               end
            end
            if (need == 3'd0 || broken || (nv < need && string_end)) begin
               cps[kc[1:0]] = u8d_pkg::ReplacementCp;
               kc           = kc + 3'd1;
               drop         = 3'd1;
            end else if (nv < need) begin
               // incomplete, wait for more bytes
               stop = 1'b1;
               drop = 3'd0;
            end else begin
               case (need)
                  3'd1:    cp = {13'b0, bv[0]};
                  3'd2:    cp = {10'b0, bv[0][4:0], bv[1][5:0]};
                  3'd3:    cp = {5'b0, bv[0][3:0], bv[1][5:0], bv[2][5:0]};
                  3'd4:    cp = {bv[0][2:0], bv[1][5:0], bv[2][5:0], bv[3][5:0]};
                  default: cp = '0;
               endcase
               // surrogates and values past the unicode range vanish
               if (cp <= u8d_pkg::MaxScalar &&
                   !(cp >= u8d_pkg::SurrLow && cp <= u8d_pkg::SurrHigh)) begin
                  cps[kc[1:0]] = cp;
                  kc           = kc + 3'd1;
               end
               drop = need;
            end
            tmp = bv;
            for (int j = 0; j < 4; j++) begin
               jd    = 3'(j) + drop;
               bv[j] = (jd < 3'd4) ? tmp[jd[1:0]] : 8'h00;
            end
            nv = nv - drop;
         end
      end
      dec.cp         = cps;
      dec.cnt        = kc;
      dec.pend_bytes = {bv[2], bv[1], bv[0]};
      dec.pend_cnt   = nv[1:0];
   end

endmodule

`default_nettype wire

// ===== hdl/u8d_rsp_queue.sv =====
// result register: holds the results of one byte and hands them out in order
`default_nettype none

module u8d_rsp_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire u8d_pkg::decode_type           dec,
   output logic                               can_load,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [u8d_pkg::CpWidth-1:0]        rsp_code_point,
   output logic                               rsp_run_last
);

   logic [u8d_pkg::CpWidth-1:0] cp_ff [u8d_pkg::MaxResults];
   logic [2:0]                  cnt_ff, cnt_in;
   logic [1:0]                  idx_ff, idx_in;
   logic                        take;

   assign rsp_valid      = (cnt_ff != 3'd0);
   assign rsp_code_point = cp_ff[idx_ff];
   assign rsp_run_last   = ({1'b0, idx_ff} + 3'd1 == cnt_ff);
   assign take           = rsp_valid && !rsp_stall;
   assign can_load       = !rsp_valid || (take && rsp_run_last);

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = dec.cnt;
         idx_in = 2'd0;
      end else if (take) begin
         if (rsp_run_last) begin
            cnt_in = 3'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < u8d_pkg::MaxResults; k++) begin
            cp_ff[k] <= dec.cp[k];
         end
      end
   end

`ifndef ASSERT_OFF
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, idx_ff} < cnt_ff) && (cnt_ff <= 3'd4))
      else $error("result index beyond result count");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      take && rsp_run_last && !load |=> !rsp_valid)
      else $error("results left after last one taken");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("result register loaded while still busy");
`endif

endmodule

`default_nettype wire

// ===== hdl/utf8_codepoint_decoder.sv =====
// UTF-8 byte stream to Unicode code point decoder, top level
// Channels: req_ takes one byte of a string per item (req_text_byte) with
// req_string_end marking the final byte; rsp_ gives code points one per item,
// rsp_run_last set on the last result caused by a byte.
// A byte is accepted on a rising edge with req_valid high and req_stall low;
// a result likewise with rsp_valid high and rsp_stall low.
// An accepted byte waits in the input register, is decoded combinationally,
// and its results are loaded into the result register and handed out there.
// Throughput: one byte per cycle while rsp_stall stays low and each byte gives
// no result or one; a byte with more results holds the result register until
// the single result port has handed out its last one.
// Bytes of an unfinished sequence (up to three) wait in the pending register.
// Reset (synchronous, active high) empties the input register, the result
// register and the pending byte count.
// While rsp_stall is high the current result holds, one more byte is taken into
// the input register, and req_stall then rises until the result register frees.
`default_nettype none

module utf8_codepoint_decoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [u8d_pkg::ByteWidth-1:0]   req_text_byte,
   input  wire logic                            req_string_end,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [u8d_pkg::CpWidth-1:0]          rsp_code_point,
   output logic                                 rsp_run_last
);

   logic                                in_valid_ff, in_valid_in;
   logic [u8d_pkg::ByteWidth-1:0]       in_byte_ff;
   logic                                in_end_ff;
   logic [u8d_pkg::PendDepth-1:0][u8d_pkg::ByteWidth-1:0] pend_bytes_ff;
   logic [1:0]                          pend_cnt_ff, pend_cnt_in;
   logic                                accept;
   logic                                move;
   logic                                can_load;
   u8d_pkg::decode_type                 dec;

   assign move      = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
      pend_cnt_in = move ? dec.pend_cnt : pend_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pend_cnt_ff <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_text_byte;
         in_end_ff  <= req_string_end;
      end
      if (move) begin
         pend_bytes_ff <= dec.pend_bytes;
      end
   end

   u8d_decode u_decode (
      .pend_bytes (pend_bytes_ff),
      .pend_cnt   (pend_cnt_ff),
      .text_byte  (in_byte_ff),
      .string_end (in_end_ff),
      .dec        (dec)
   );

   u8d_rsp_queue u_rsp_queue (
      .clock          (clock),
      .reset          (reset),
      .load           (move),
      .dec            (dec),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_run_last   (rsp_run_last)
   );

`ifndef ASSERT_OFF
   a_pend_is_lead: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff != 2'd0 |-> (pend_bytes_ff[0][7:5] == 3'b110 ||
                               pend_bytes_ff[0][7:4] == 4'b1110 ||
                               pend_bytes_ff[0][7:3] == 5'b11110))
      else $error("pending sequence does not start with a lead byte");

   a_end_flushes: assert property (@(posedge clock) disable iff (reset)
      move && in_end_ff |=> pend_cnt_ff == 2'd0)
      else $error("bytes still pending after string end");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !move |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_end_ff))
      else $error("waiting input item lost or changed");
`endif

endmodule

`default_nettype wire

// ===== tb/utf8_decode_checker.sv =====
// checker for the utf-8 decoder: predicts code points from accepted bytes and compares results
`timescale 1ns / 100ps

module utf8_decode_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [u8d_pkg::ByteWidth-1:0] req_text_byte,
   input  wire logic                          req_string_end,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [u8d_pkg::CpWidth-1:0]   rsp_code_point,
   input  wire logic                          rsp_run_last,
   output int                                 bytes_taken,
   output int                                 cps_checked,
   output int                                 cps_due,
   output int                                 mismatches
);

   typedef struct packed {
      logic [u8d_pkg::CpWidth-1:0] cp;
      logic                        last;
   } cp_item_type;

   cp_item_type                   expected_cps [$];
   logic [u8d_pkg::ByteWidth-1:0] held_bytes [u8d_pkg::PendDepth];
   int unsigned                   held_cnt;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // decode one byte against the held bytes, queue the code points it yields
   function automatic void predict_byte(input logic [u8d_pkg::ByteWidth-1:0] b,
                                        input logic at_end);
      logic [u8d_pkg::ByteWidth-1:0] win [4];
      logic [u8d_pkg::CpWidth-1:0]   found [u8d_pkg::MaxResults];
      logic [u8d_pkg::CpWidth-1:0]   cp;
      int unsigned                   n;
      int unsigned                   need;
      int unsigned                   used;
      int unsigned                   k;
      logic                          broken;
      logic                          waiting;
      for (int i = 0; i < u8d_pkg::PendDepth; i++) win[i] = held_bytes[i];
      win[3] = 8'h00;
      n = held_cnt;
      win[n] = b;
      n++;
      k = 0;
      waiting = 1'b0;
      cp = '0;
      while (n > 0 && !waiting) begin
         casez (win[0])
            8'b0???????: need = 1;
            8'b110?????: need = 2;
            8'b1110????: need = 3;
            8'b11110???: need = 4;
            default:     need = 0;
         endcase
         broken = 1'b0;
         for (int i = 1; i < 4; i++)
            if (i < need && i < n && win[i][7:6] != 2'b10) broken = 1'b1;
         used = 0;
         if (need == 0 || broken || (n < need && at_end)) begin
            // only the lead byte goes, the rest is looked at again
            cp = u8d_pkg::ReplacementCp;
            used = 1;
         end else if (n < need) begin
            waiting = 1'b1;
         end else begin
            case (need)
               1:       cp = {13'd0, win[0]};
               2:       cp = {10'd0, win[0][4:0], win[1][5:0]};
               3:       cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
               default: cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
            endcase
            used = need;
         end
         if (used != 0) begin
            // surrogates and values past the last scalar vanish without a result
            if (cp <= u8d_pkg::MaxScalar &&
                !(cp >= u8d_pkg::SurrLow && cp <= u8d_pkg::SurrHigh) &&
                k < u8d_pkg::MaxResults) begin
               found[k] = cp;
               k++;
            end
            for (int i = 0; i < 3; i++)
               if (i + used < n) win[i] = win[i + used];
            n -= used;
         end
      end
      held_cnt = n;
      for (int i = 0; i < u8d_pkg::PendDepth; i++) held_bytes[i] = win[i];
      for (int j = 0; j < k; j++) expected_cps.push_back({found[j], j == k - 1});
   endfunction

   always @(posedge clock) begin : watch
      cp_item_type want;
      if (reset) begin
         held_cnt = 0;
         expected_cps.delete();
      end else begin
         if (req_valid && !req_stall) begin
            bytes_taken++;
            predict_byte(req_text_byte, req_string_end);
         end
         if (rsp_valid && !rsp_stall) begin
            cps_checked++;
            if (expected_cps.size() == 0) begin
               report_mismatch($sformatf("code point %h with none expected", rsp_code_point));
            end else begin
               want = expected_cps.pop_front();
               if (rsp_code_point !== want.cp)
                  report_mismatch($sformatf("code point %h, expected %h",
                                            rsp_code_point, want.cp));
               if (rsp_run_last !== want.last)
                  report_mismatch($sformatf("run_last %b, expected %b for code point %h",
                                            rsp_run_last, want.last, want.cp));
            end
         end
      end
      cps_due = expected_cps.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// top of the utf-8 decoder testbench: clock, reset, byte strings and verdict
`timescale 1ns / 100ps

module tb_top;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic [u8d_pkg::ByteWidth-1:0] req_text_byte  = 8'h41;
   logic                          req_string_end = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic [u8d_pkg::CpWidth-1:0]   rsp_code_point;
   logic                          rsp_run_last;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int sent_bytes    = 0;
   int strings_sent  = 0;
   int bytes_taken;
   int cps_checked;
   int cps_due;
   int mismatches;

   logic [u8d_pkg::ByteWidth-1:0] text_q [$];

   always #5 clock = ~clock;

   utf8_codepoint_decoder uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_run_last   (rsp_run_last)
   );

   utf8_decode_checker watcher (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_run_last   (rsp_run_last),
      .bytes_taken    (bytes_taken),
      .cps_checked    (cps_checked),
      .cps_due        (cps_due),
      .mismatches     (mismatches)
   );

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

   task automatic send_byte(input logic [u8d_pkg::ByteWidth-1:0] b, input logic last_byte);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_string_end <= last_byte;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
   endtask

   // the whole queued string, string_end on its final item
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
      strings_sent++;
   endtask

   task automatic send_word(input logic [31:0] w, input int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) text_q.push_back(w[8*i +: 8]);
      send_text();
   endtask

   // encode in the given length, so short values come out overlong
   task automatic add_char(input int unsigned cp, input int len);
      case (len)
         1: text_q.push_back({1'b0, cp[6:0]});
         2: begin
            text_q.push_back({3'b110, cp[10:6]});
            text_q.push_back({2'b10, cp[5:0]});
         end
         3: begin
            text_q.push_back({4'b1110, cp[15:12]});
            text_q.push_back({2'b10, cp[11:6]});
            text_q.push_back({2'b10, cp[5:0]});
         end
         default: begin
            text_q.push_back({5'b11110, cp[20:18]});
            text_q.push_back({2'b10, cp[17:12]});
            text_q.push_back({2'b10, cp[11:6]});
            text_q.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic random_string();
      int          chars;
      int          kind;
      int          len;
      int unsigned r;
      chars = $urandom_range(1, 8);
      for (int c = 0; c < chars; c++) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            add_char($urandom_range(1, 127), 1);
         end else if (kind < 53) begin
            add_char($urandom_range(32'h80, 32'h7FF), 2);
         end else if (kind < 66) begin
            add_char($urandom_range(32'h800, 32'hFFFF), 3);
         end else if (kind < 76) begin
            add_char($urandom_range(32'h10000, 32'h10FFFF), 4);
         end else if (kind < 79) begin
            add_char($urandom_range(32'h110000, 32'h1FFFFF), 4);
         end else if (kind < 82) begin
            add_char($urandom_range(32'hD800, 32'hDFFF), 3);
         end else if (kind < 86) begin
            add_char($urandom_range(0, 127), $urandom_range(2, 4));
         end else if (kind < 90) begin
            r = $urandom_range(32'h80, 32'hBF);
            text_q.push_back(r[7:0]);
         end else if (kind < 93) begin
            r = $urandom_range(32'hF8, 32'hFF);
            text_q.push_back(r[7:0]);
         end else begin
            // lead byte missing some of its continuations
            len = $urandom_range(2, 4);
            add_char($urandom, len);
            repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
         end
      end
      send_text();
   endtask

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      send_idle_pct = 20;
      rsp_idle_pct  = 72;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(32'h0000_7F01, 2);
      send_word(32'h0000_C280, 2);
      send_word(32'h00EF_BFBF, 3);
      send_word(32'h00ED_A080, 3);
      send_word(32'hF48F_BFBF, 4);
      send_word(32'hF490_8080, 4);
      send_word(32'h0000_80FF, 2);
      send_word(32'hF090_8041, 4);
      send_word(32'h0000_E282, 2);

      while (sent_bytes < 180) random_string();
      send_idle_pct = 72;
      rsp_idle_pct  = 20;
      while (sent_bytes < 340) random_string();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      while (sent_bytes < 465) random_string();

      @(negedge clock);
      req_valid <= 1'b0;
      while (cps_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("%0d bytes in %0d strings decoded, %0d code points checked",
               bytes_taken, strings_sent, cps_checked);
      $display("stall mix: slow receiver, then slow sender, then back-to-back traffic");
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
